// ----- rtl/sosat_pkg.sv -----
`default_nettype none
package sosat_pkg;

    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 30;
    localparam int DEF_STATE_BITS     = 40;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_TRIM    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_PAD    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGHPASS_RATE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_A0       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_B1       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_B2       = 3'd5;

    localparam logic [31:0]        RST_INPUT_TRIM    = 32'd65536;
    localparam logic [16:0]        RST_OUTPUT_PAD    = 17'd65536;
    localparam logic [31:0]        RST_HIGHPASS_RATE = 32'd2963527;
    localparam logic [30:0]        RST_COEF_A0       = 31'd600874000;
    localparam logic signed [31:0] RST_COEF_B1       = 32'sd900126000;
    localparam logic signed [31:0] RST_COEF_B2       = 32'sd429712000;

    localparam int COEF_W     = 34;
    localparam int SHAPE_K    = 189837554;
    localparam int SHAPE_FRAC = 30;
    localparam int TRIM_FRAC  = 16;
    localparam int RATE_FRAC  = 32;
    localparam int PAD_FRAC   = 16;

endpackage
`default_nettype wire

// ----- rtl/sosat_if.sv -----
`default_nettype none
interface sosat_sample_if import sosat_pkg::*; #(parameter int SB = DEF_SAMPLE_BITS);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] sample_left;
    logic signed [SB-1:0] sample_right;
    modport source (output valid, sample_left, sample_right, input ready);
    modport sink (input valid, sample_left, sample_right, output ready);
endinterface

interface sosat_result_if import sosat_pkg::*; #(parameter int SB = DEF_SAMPLE_BITS);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] out_left;
    logic signed [SB-1:0] out_right;
    modport source (output valid, out_left, out_right, input ready);
    modport sink (input valid, out_left, out_right, output ready);
endinterface

interface sosat_cfg_if import sosat_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/stereo_output_stage_saturator_top.sv -----
// Stereo output stage: per channel, input trim, one-pole tracker highpass, lowpass
// biquad, clip and x - 0.1768*x^5 shaping, second biquad, output pad, saturation to
// the sample width. One word in gives one word out, and the next frame can be
// accepted in the cycle after the result register is loaded. One shared two-pass
// multiplier works through 17 products per channel, with filter and tracker state
// read from and written back to an 18-entry state memory. The next frame is accepted
// while a result still waits on the output side.
`default_nettype none
module stereo_output_stage_saturator_top import sosat_pkg::*; #(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int STATE_BITS     = DEF_STATE_BITS
) (
    input  wire          clk,
    input  wire          rst_n,
    sosat_cfg_if.sink    cfg,
    sosat_sample_if.sink samples,
    sosat_result_if.source results
);

    localparam int W  = STATE_BITS;
    localparam int AW = W + 1;
    localparam int EW = W + 3;
    localparam int CW = COEF_W;
    localparam int PW = AW + CW;
    localparam int LO = AW / 2;
    localparam int HW = AW - LO;
    localparam int SB = SAMPLE_BITS;
    localparam int FR = SB - 1;

    localparam logic signed [PW-1:0] MAX_P  = (PW'(1) << (W - 1)) - PW'(1);
    localparam logic signed [PW-1:0] MIN_P  = ~MAX_P;
    localparam logic signed [EW-1:0] MAX_E  = (EW'(1) << (W - 1)) - EW'(1);
    localparam logic signed [EW-1:0] MIN_E  = ~MAX_E;
    localparam logic signed [W-1:0]  MAX_S  = (W'(1) << (SB - 1)) - W'(1);
    localparam logic signed [W-1:0]  MIN_S  = ~MAX_S;
    localparam logic signed [W-1:0]  ONE_W  = W'(1) << FR;
    localparam logic signed [W-1:0]  NONE_W = -ONE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    localparam logic [2:0] PH_READ = 3'd0;
    localparam logic [2:0] PH_LOAD = 3'd1;
    localparam logic [2:0] PH_LOW  = 3'd2;
    localparam logic [2:0] PH_HIGH = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic [4:0] OP_TRIM  = 5'd0;
    localparam logic [4:0] OP_TRACK = 5'd1;
    localparam logic [4:0] OP_B1X2  = 5'd2;
    localparam logic [4:0] OP_B1X1  = 5'd3;
    localparam logic [4:0] OP_B1X0  = 5'd4;
    localparam logic [4:0] OP_B1Y2  = 5'd5;
    localparam logic [4:0] OP_B1Y1  = 5'd6;
    localparam logic [4:0] OP_SQ    = 5'd7;
    localparam logic [4:0] OP_X4    = 5'd8;
    localparam logic [4:0] OP_X5    = 5'd9;
    localparam logic [4:0] OP_SHAPE = 5'd10;
    localparam logic [4:0] OP_B2X2  = 5'd11;
    localparam logic [4:0] OP_B2X1  = 5'd12;
    localparam logic [4:0] OP_B2X0  = 5'd13;
    localparam logic [4:0] OP_B2Y2  = 5'd14;
    localparam logic [4:0] OP_B2Y1  = 5'd15;
    localparam logic [4:0] OP_PAD   = 5'd16;

    localparam logic [3:0] K_TRK  = 4'd0;
    localparam logic [3:0] K_1X1  = 4'd1;
    localparam logic [3:0] K_1X2  = 4'd2;
    localparam logic [3:0] K_1Y1  = 4'd3;
    localparam logic [3:0] K_1Y2  = 4'd4;
    localparam logic [3:0] K_2X1  = 4'd5;
    localparam logic [3:0] K_2X2  = 4'd6;
    localparam logic [3:0] K_2Y1  = 4'd7;
    localparam logic [3:0] K_2Y2  = 4'd8;
    localparam int         DEPTH  = 18;
    localparam logic [4:0] CH_OFS = 5'd9;

    function automatic logic signed [W-1:0] sat_e(input logic signed [EW-1:0] v);
        if (v > MAX_E)
            return MAX_E[W-1:0];
        else if (v < MIN_E)
            return MIN_E[W-1:0];
        else
            return v[W-1:0];
    endfunction

    logic [31:0]        trim_reg;
    logic [16:0]        pad_reg;
    logic [31:0]        rate_reg;
    logic [30:0]        a0_reg;
    logic signed [31:0] b1_reg;
    logic signed [31:0] b2_reg;

    logic [1:0] state_reg, state_next;
    logic [4:0] op_reg, op_next;
    logic [2:0] ph_reg, ph_next;
    logic       ch_reg, ch_next;

    logic signed [SB-1:0] left_reg, right_reg;
    logic signed [SB-1:0] res_l_reg, res_r_reg;
    logic signed [SB-1:0] out_l_reg, out_r_reg;
    logic                 out_valid_reg;

    logic signed [W-1:0]  x_reg, hold_reg, cl_reg, p_reg;
    logic signed [EW-1:0] acc_reg;
    logic signed [AW-1:0] a_reg;
    logic signed [CW-1:0] c_reg;
    logic signed [PW-1:0] prod_reg;

    logic signed [W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    mvalid_reg;
    logic signed [W-1:0] rdata_reg;
    logic                rvalid_reg;

    logic [3:0]          rd_k, wr_k;
    logic [4:0]          rd_addr, wr_addr;
    logic                wr_en;
    logic signed [W-1:0] wr_data;

    logic signed [W-1:0]    rv, clip_x, r, tn, x_trk, y_out;
    logic signed [SB-1:0]   sample_ch, out_sat;
    logic signed [AW-1:0]   a_sel;
    logic signed [CW-1:0]   c_sel;
    logic signed [PW-1:0]   sh;
    logic signed [LO+CW:0]  p_lo;
    logic signed [HW+CW-1:0] p_hi;
    logic                   accept, load_out, at_done;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign at_done       = (state_reg == ST_RUN) && (ph_reg == PH_DONE);
    assign load_out      = (state_reg == ST_POST) && (!out_valid_reg || results.ready);

    assign results.valid     = out_valid_reg;
    assign results.out_left  = out_l_reg;
    assign results.out_right = out_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= RST_INPUT_TRIM;
            pad_reg  <= RST_OUTPUT_PAD;
            rate_reg <= RST_HIGHPASS_RATE;
            a0_reg   <= RST_COEF_A0;
            b1_reg   <= RST_COEF_B1;
            b2_reg   <= RST_COEF_B2;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_INPUT_TRIM:    trim_reg <= cfg.data;
                CFG_OUTPUT_PAD:    pad_reg  <= cfg.data[16:0];
                CFG_HIGHPASS_RATE: rate_reg <= cfg.data;
                CFG_COEF_A0:       a0_reg   <= cfg.data[30:0];
                CFG_COEF_B1:       b1_reg   <= $signed(cfg.data);
                CFG_COEF_B2:       b2_reg   <= $signed(cfg.data);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ph_next    = ph_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    op_next    = OP_TRIM;
                    ph_next    = PH_READ;
                    ch_next    = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (ph_reg == PH_DONE)
                begin
                    ph_next = PH_READ;
                    if (op_reg == OP_PAD)
                    begin
                        op_next = OP_TRIM;
                        if (ch_reg)
                            state_next = ST_POST;
                        else
                            ch_next = 1'b1;
                    end
                    else
                        op_next = op_reg + 5'd1;
                end
                else
                    ph_next = ph_reg + 3'd1;
            end
            ST_POST:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TRIM;
            ph_reg        <= PH_READ;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ph_reg    <= ph_next;
            ch_reg    <= ch_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_TRACK: rd_k = K_TRK;
            OP_B1X2:  rd_k = K_1X2;
            OP_B1X1:  rd_k = K_1X1;
            OP_B1Y2:  rd_k = K_1Y2;
            OP_B1Y1:  rd_k = K_1Y1;
            OP_B2X2:  rd_k = K_2X2;
            OP_B2X1:  rd_k = K_2X1;
            OP_B2Y2:  rd_k = K_2Y2;
            OP_B2Y1:  rd_k = K_2Y1;
            default:  rd_k = K_TRK;
        endcase
    end

    assign rd_addr = {1'b0, rd_k} + (ch_reg ? CH_OFS : 5'd0);
    assign wr_addr = {1'b0, wr_k} + (ch_reg ? CH_OFS : 5'd0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                mvalid_reg[wr_addr] <= 1'b1;
            rvalid_reg <= mvalid_reg[rd_addr];
        end
    end

    assign rv        = rvalid_reg ? rdata_reg : '0;
    assign sample_ch = ch_reg ? right_reg : left_reg;
    assign clip_x    = (x_reg > ONE_W) ? ONE_W : ((x_reg < NONE_W) ? NONE_W : x_reg);

    always_comb
    begin
        case (op_reg)
            OP_TRIM:  a_sel = AW'(sample_ch);
            OP_TRACK: a_sel = AW'(x_reg) - AW'(rv);
            OP_B1X2, OP_B1X1, OP_B1Y2, OP_B1Y1,
            OP_B2X2, OP_B2X1, OP_B2Y2, OP_B2Y1:
                      a_sel = AW'(rv);
            OP_B1X0, OP_B2X0, OP_PAD:
                      a_sel = AW'(x_reg);
            OP_SQ:    a_sel = AW'(clip_x);
            OP_X4, OP_X5, OP_SHAPE:
                      a_sel = AW'(p_reg);
            default:  a_sel = '0;
        endcase
        case (op_reg)
            OP_TRIM:  c_sel = CW'(trim_reg);
            OP_TRACK: c_sel = CW'(rate_reg);
            OP_B1X2, OP_B1X0, OP_B2X2, OP_B2X0:
                      c_sel = CW'(a0_reg);
            OP_B1X1, OP_B2X1:
                      c_sel = CW'({a0_reg, 1'b0});
            OP_B1Y2, OP_B2Y2:
                      c_sel = CW'(b2_reg);
            OP_B1Y1, OP_B2Y1:
                      c_sel = CW'(b1_reg);
            OP_SQ:    c_sel = CW'(clip_x);
            OP_X4:    c_sel = CW'(p_reg);
            OP_X5:    c_sel = CW'(cl_reg);
            OP_SHAPE: c_sel = CW'(SHAPE_K);
            OP_PAD:   c_sel = CW'(pad_reg);
            default:  c_sel = '0;
        endcase
    end

    assign p_lo = $signed({1'b0, a_reg[LO-1:0]}) * c_reg;
    assign p_hi = $signed(a_reg[AW-1:LO]) * c_reg;

    always_comb
    begin
        case (op_reg)
            OP_TRIM, OP_PAD:
                sh = prod_reg >>> TRIM_FRAC;
            OP_TRACK:
                sh = prod_reg >>> RATE_FRAC;
            OP_SQ, OP_X4, OP_X5:
                sh = prod_reg >>> FR;
            OP_SHAPE:
                sh = prod_reg >>> SHAPE_FRAC;
            default:
                sh = prod_reg >>> COEF_FRAC_BITS;
        endcase
    end

    assign r       = (sh > MAX_P) ? MAX_P[W-1:0] : ((sh < MIN_P) ? MIN_P[W-1:0] : sh[W-1:0]);
    assign tn      = sat_e(EW'(hold_reg) + EW'(r));
    assign x_trk   = sat_e(EW'(x_reg) - EW'(tn));
    assign y_out   = sat_e(acc_reg - EW'(r));
    assign out_sat = (r > MAX_S) ? MAX_S[SB-1:0] : ((r < MIN_S) ? MIN_S[SB-1:0] : r[SB-1:0]);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_k    = K_TRK;
        wr_data = x_reg;
        if (at_done)
        begin
            case (op_reg)
                OP_TRACK:
                begin
                    wr_en   = 1'b1;
                    wr_k    = K_TRK;
                    wr_data = tn;
                end
                OP_B1X1:
                begin
                    wr_en   = 1'b1;
                    wr_k    = K_1X2;
                    wr_data = hold_reg;
                end
                OP_B1X0:
                begin
                    wr_en = 1'b1;
                    wr_k  = K_1X1;
                end
                OP_B1Y1:
                begin
                    wr_en   = 1'b1;
                    wr_k    = K_1Y2;
                    wr_data = hold_reg;
                end
                OP_SQ:
                begin
                    wr_en = 1'b1;
                    wr_k  = K_1Y1;
                end
                OP_B2X1:
                begin
                    wr_en   = 1'b1;
                    wr_k    = K_2X2;
                    wr_data = hold_reg;
                end
                OP_B2X0:
                begin
                    wr_en = 1'b1;
                    wr_k  = K_2X1;
                end
                OP_B2Y1:
                begin
                    wr_en   = 1'b1;
                    wr_k    = K_2Y2;
                    wr_data = hold_reg;
                end
                OP_PAD:
                begin
                    wr_en = 1'b1;
                    wr_k  = K_2Y1;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= samples.sample_left;
            right_reg <= samples.sample_right;
        end
        if (load_out)
        begin
            out_l_reg <= res_l_reg;
            out_r_reg <= res_r_reg;
        end
        if (state_reg == ST_RUN)
        begin
            case (ph_reg)
                PH_LOAD:
                begin
                    hold_reg <= rv;
                    a_reg    <= a_sel;
                    c_reg    <= c_sel;
                    if (op_reg == OP_SQ)
                        cl_reg <= clip_x;
                end
                PH_LOW:
                    prod_reg <= PW'(p_lo);
                PH_HIGH:
                    prod_reg <= prod_reg + (PW'(p_hi) <<< LO);
                PH_DONE:
                begin
                    case (op_reg)
                        OP_TRIM:  x_reg <= r;
                        OP_TRACK: x_reg <= x_trk;
                        OP_B1X2, OP_B2X2:
                                  acc_reg <= EW'(r);
                        OP_B1X1, OP_B1X0, OP_B2X1, OP_B2X0:
                                  acc_reg <= acc_reg + EW'(r);
                        OP_B1Y2, OP_B2Y2:
                                  acc_reg <= acc_reg - EW'(r);
                        OP_B1Y1, OP_B2Y1:
                                  x_reg <= y_out;
                        OP_SQ, OP_X4, OP_X5:
                                  p_reg <= r;
                        OP_SHAPE: x_reg <= cl_reg - r;
                        OP_PAD:
                        begin
                            if (ch_reg)
                                res_r_reg <= out_sat;
                            else
                                res_l_reg <= out_sat;
                        end
                        default:  ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg <= PH_DONE && op_reg <= OP_PAD)
        else $error("sequencer phase or step out of range");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> (ph_reg == PH_READ && op_reg == OP_TRIM))
        else $error("sequencer not parked outside run");

    a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_RUN)
        else $error("state memory written outside run");

    a_out_from_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_POST)
        else $error("result word raised without finished frame");

endmodule
`default_nettype wire
